/* src/hslp_pkg.sv */
// Package for the HTTP status line parser: item types, byte classes,
// parse phases, result codes and the shared arithmetic helper.
// No dependencies.
`timescale 1ns / 1ps

package hslp_pkg;

    localparam int MAX_BUFFER_BYTES = 4096;
    localparam int DESC_CAPACITY    = 256;
    localparam int POS_W            = 12;
    localparam int VAL_W            = 10;
    localparam int LEN_W            = 8;
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_BUFFER_BYTES - 1);
    localparam logic [POS_W-1:0] LEN_CLAMP = POS_W'(DESC_CAPACITY - 1);
    localparam logic [VAL_W-1:0] VER_MAX  = VAL_W'(999);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_BAD   = 2'd1;
    localparam logic [1:0] RES_SHORT = 2'd2;
    localparam logic [1:0] RES_NONE  = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       result_code;
        logic [VAL_W-1:0] version_major;
        logic [VAL_W-1:0] version_minor;
        logic [VAL_W-1:0] status_code;
        logic [POS_W-1:0] desc_offset;
        logic [LEN_W-1:0] desc_length;
    } out_item_t;

    typedef enum logic [3:0] {
        CLS_DIGIT = 4'd0,
        CLS_SPACE = 4'd1,
        CLS_DOT   = 4'd2,
        CLS_CR    = 4'd3,
        CLS_LF    = 4'd4,
        CLS_H     = 4'd5,
        CLS_T     = 4'd6,
        CLS_P     = 4'd7,
        CLS_SLASH = 4'd8,
        CLS_OTHER = 4'd9
    } byte_cls_t;

    // One classified byte as it travels from the front end to the parser.
    typedef struct packed {
        byte_cls_t  cls;
        logic [3:0] digit;
        logic       is_last;
    } cls_item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    typedef enum logic [12:0] {
        PH_START = 13'b0000000000001,
        PH_H     = 13'b0000000000010,
        PH_HT    = 13'b0000000000100,
        PH_HTT   = 13'b0000000001000,
        PH_HTTP  = 13'b0000000010000,
        PH_MAJ1  = 13'b0000000100000,
        PH_MAJ   = 13'b0000001000000,
        PH_MIN1  = 13'b0000010000000,
        PH_MIN   = 13'b0000100000000,
        PH_CODE  = 13'b0001000000000,
        PH_AFTER = 13'b0010000000000,
        PH_TEXT  = 13'b0100000000000,
        PH_CR    = 13'b1000000000000
    } phase_t;

    // acc * 10 + d, built from shifts and adds.
    function automatic logic [VAL_W+3:0] mul10_add(input logic [VAL_W-1:0] acc,
                                                   input logic [3:0] d);
        logic [VAL_W+3:0] a;
        a = {4'd0, acc};
        return (a << 3) + (a << 1) + {{VAL_W{1'b0}}, d};
    endfunction

endpackage

/* src/hslp_front.sv */
// Front end of the HTTP status line parser: takes input beats, classifies
// each byte and holds it in a register until the command queue takes it.
// Depends on hslp_pkg.
`timescale 1ns / 1ps

module hslp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  hslp_pkg::in_item_t  byte_beat,
    input  hslp_pkg::q_stat_t   q_stat,
    output logic                q_push,
    output hslp_pkg::cls_item_t q_item
);

    logic                valid_reg;
    logic                valid_next;
    hslp_pkg::cls_item_t item_reg;
    hslp_pkg::cls_item_t item_next;
    logic                take;

    assign q_push = valid_reg && !q_stat.full;
    assign full   = valid_reg && q_stat.full;
    assign take   = push && !full;
    assign q_item = item_reg;

    always_comb
    begin
        item_next.is_last = byte_beat.is_last;
        item_next.digit   = byte_beat.data_byte[3:0];
        if (byte_beat.data_byte >= 8'h30 && byte_beat.data_byte <= 8'h39)
        begin
            item_next.cls = hslp_pkg::CLS_DIGIT;
        end
        else
        begin
            item_next.digit = 4'd0;
            case (byte_beat.data_byte)
                8'h20:   item_next.cls = hslp_pkg::CLS_SPACE;
                8'h2E:   item_next.cls = hslp_pkg::CLS_DOT;
                8'h0D:   item_next.cls = hslp_pkg::CLS_CR;
                8'h0A:   item_next.cls = hslp_pkg::CLS_LF;
                8'h48:   item_next.cls = hslp_pkg::CLS_H;
                8'h54:   item_next.cls = hslp_pkg::CLS_T;
                8'h50:   item_next.cls = hslp_pkg::CLS_P;
                8'h2F:   item_next.cls = hslp_pkg::CLS_SLASH;
                default: item_next.cls = hslp_pkg::CLS_OTHER;
            endcase
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (q_push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* src/hslp_cmd_queue.sv */
// Short queue of classified bytes between the front end and the parser.
// Depends on hslp_pkg.
`timescale 1ns / 1ps

module hslp_cmd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  hslp_pkg::cls_item_t wr_item,
    input  logic                rd_en,
    output hslp_pkg::cls_item_t rd_item,
    output hslp_pkg::q_stat_t   stat
);

    hslp_pkg::cls_item_t           mem [hslp_pkg::QUEUE_DEPTH];
    logic [hslp_pkg::QPTR_W-1:0]   wptr_reg;
    logic [hslp_pkg::QPTR_W-1:0]   wptr_next;
    logic [hslp_pkg::QPTR_W-1:0]   rptr_reg;
    logic [hslp_pkg::QPTR_W-1:0]   rptr_next;
    logic [hslp_pkg::QPTR_W:0]     count_reg;
    logic [hslp_pkg::QPTR_W:0]     count_next;
    logic                          do_wr;
    logic                          do_rd;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (hslp_pkg::QPTR_W+1)'(hslp_pkg::QUEUE_DEPTH));
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_item    = mem[rptr_reg];

    always_comb
    begin
        wptr_next  = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

endmodule

/* src/hslp_back.sv */
// Back end of the HTTP status line parser: the parse state machine, which
// consumes classified bytes, and a two-entry result queue.
// Depends on hslp_pkg.
`timescale 1ns / 1ps

module hslp_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  hslp_pkg::q_stat_t   q_stat,
    input  hslp_pkg::cls_item_t q_item,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output hslp_pkg::out_item_t verdict
);

    localparam int VW = hslp_pkg::VAL_W;
    localparam int PW = hslp_pkg::POS_W;

    hslp_pkg::phase_t phase_reg, phase_next;
    logic [VW-1:0]    major_reg, major_next;
    logic [VW-1:0]    minor_reg, minor_next;
    logic [VW-1:0]    code_reg, code_next;
    logic [1:0]       digits_reg, digits_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    dstart_reg, dstart_next;
    logic             verdict_reg, verdict_next;

    hslp_pkg::out_item_t out_mem [2];
    logic                out_wptr_reg, out_rptr_reg;
    logic [1:0]          out_cnt_reg, out_cnt_next;
    logic                out_wr, out_rd;

    logic [1:0]          res;
    logic [PW-1:0]       end_pos;
    logic [PW-1:0]       span;
    hslp_pkg::out_item_t res_item;
    logic [VW+3:0]       maj_sum, min_sum, code_sum;
    logic [VW-1:0]       major_upd, minor_upd, code_upd;
    logic [1:0]          digits_inc;
    logic                is_dig;
    logic                take;

    assign take    = !q_stat.empty && (out_cnt_reg != 2'd2);
    assign q_pop   = take;
    assign is_dig  = (q_item.cls == hslp_pkg::CLS_DIGIT);
    assign maj_sum = hslp_pkg::mul10_add(major_reg, q_item.digit);
    assign min_sum = hslp_pkg::mul10_add(minor_reg, q_item.digit);
    assign code_sum = hslp_pkg::mul10_add(code_reg, q_item.digit);
    assign digits_inc = digits_reg + 2'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        code_next    = code_reg;
        digits_next  = digits_reg;
        pos_next     = pos_reg;
        dstart_next  = dstart_reg;
        verdict_next = verdict_reg;
        res          = hslp_pkg::RES_NONE;
        end_pos      = '0;

        if (take && !verdict_reg)
        begin
            unique case (phase_reg)
                hslp_pkg::PH_START:
                    if (q_item.cls == hslp_pkg::CLS_H) phase_next = hslp_pkg::PH_H;
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_H:
                    if (q_item.cls == hslp_pkg::CLS_T) phase_next = hslp_pkg::PH_HT;
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_HT:
                    if (q_item.cls == hslp_pkg::CLS_T) phase_next = hslp_pkg::PH_HTT;
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_HTT:
                    if (q_item.cls == hslp_pkg::CLS_P) phase_next = hslp_pkg::PH_HTTP;
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_HTTP:
                    if (q_item.cls == hslp_pkg::CLS_SLASH) phase_next = hslp_pkg::PH_MAJ1;
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_MAJ1:
                    if (is_dig && q_item.digit != 4'd0)
                    begin
                        major_next = {{(VW-4){1'b0}}, q_item.digit};
                        phase_next = hslp_pkg::PH_MAJ;
                    end
                    else
                    begin
                        res = hslp_pkg::RES_BAD;
                    end
                hslp_pkg::PH_MAJ:
                    if (q_item.cls == hslp_pkg::CLS_DOT) phase_next = hslp_pkg::PH_MIN1;
                    else if (is_dig)
                        major_next = (maj_sum > {4'd0, hslp_pkg::VER_MAX}) ?
                                     hslp_pkg::VER_MAX : maj_sum[VW-1:0];
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_MIN1:
                    if (is_dig)
                    begin
                        minor_next = {{(VW-4){1'b0}}, q_item.digit};
                        phase_next = hslp_pkg::PH_MIN;
                    end
                    else
                    begin
                        res = hslp_pkg::RES_BAD;
                    end
                hslp_pkg::PH_MIN:
                    if (q_item.cls == hslp_pkg::CLS_SPACE) phase_next = hslp_pkg::PH_CODE;
                    else if (is_dig)
                        minor_next = (min_sum > {4'd0, hslp_pkg::VER_MAX}) ?
                                     hslp_pkg::VER_MAX : min_sum[VW-1:0];
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_CODE:
                    if (is_dig)
                    begin
                        code_next   = code_sum[VW-1:0];
                        digits_next = digits_inc;
                        if (digits_inc == 2'd3)
                        begin
                            phase_next  = hslp_pkg::PH_AFTER;
                            dstart_next = pos_reg - PW'(2);
                        end
                    end
                    else if (q_item.cls != hslp_pkg::CLS_SPACE)
                    begin
                        res = hslp_pkg::RES_BAD;
                    end
                hslp_pkg::PH_AFTER:
                    if (q_item.cls == hslp_pkg::CLS_SPACE || q_item.cls == hslp_pkg::CLS_DOT)
                        phase_next = hslp_pkg::PH_TEXT;
                    else if (q_item.cls == hslp_pkg::CLS_CR) phase_next = hslp_pkg::PH_CR;
                    else if (q_item.cls == hslp_pkg::CLS_LF)
                    begin
                        res     = hslp_pkg::RES_OK;
                        end_pos = pos_reg;
                    end
                    else res = hslp_pkg::RES_BAD;
                hslp_pkg::PH_TEXT:
                    if (q_item.cls == hslp_pkg::CLS_CR) phase_next = hslp_pkg::PH_CR;
                    else if (q_item.cls == hslp_pkg::CLS_LF)
                    begin
                        res     = hslp_pkg::RES_OK;
                        end_pos = pos_reg;
                    end
                hslp_pkg::PH_CR:
                    if (q_item.cls == hslp_pkg::CLS_LF)
                    begin
                        res     = hslp_pkg::RES_OK;
                        end_pos = pos_reg - PW'(1);
                    end
                    else
                    begin
                        res = hslp_pkg::RES_BAD;
                    end
                default:
                    res = hslp_pkg::RES_BAD;
            endcase

            if (res == hslp_pkg::RES_NONE && q_item.is_last)
            begin
                res = hslp_pkg::RES_SHORT;
            end
            if (res != hslp_pkg::RES_NONE)
            begin
                verdict_next = 1'b1;
            end
            if (pos_reg != hslp_pkg::POS_MAX)
            begin
                pos_next = pos_reg + PW'(1);
            end
        end

        // The verdict reports the values as updated by this byte, taken
        // before the end-of-buffer clear below.
        major_upd = major_next;
        minor_upd = minor_next;
        code_upd  = code_next;

        // The final byte of a buffer always returns the parser to its start.
        if (take && q_item.is_last)
        begin
            phase_next   = hslp_pkg::PH_START;
            major_next   = '0;
            minor_next   = '0;
            code_next    = '0;
            digits_next  = '0;
            pos_next     = '0;
            dstart_next  = '0;
            verdict_next = 1'b0;
        end
    end

    always_comb
    begin
        span                   = end_pos - dstart_reg;
        res_item.result_code   = res;
        res_item.version_major = major_upd;
        res_item.version_minor = minor_upd;
        res_item.status_code   = code_upd;
        res_item.desc_offset   = '0;
        res_item.desc_length   = '0;
        if (res == hslp_pkg::RES_OK)
        begin
            res_item.desc_offset = dstart_reg;
            res_item.desc_length = (span > hslp_pkg::LEN_CLAMP) ?
                                   hslp_pkg::LEN_CLAMP[hslp_pkg::LEN_W-1:0] :
                                   span[hslp_pkg::LEN_W-1:0];
        end
    end

    assign out_wr  = take && !verdict_reg && (res != hslp_pkg::RES_NONE);
    assign empty   = (out_cnt_reg == 2'd0);
    assign out_rd  = pop && !empty;
    assign verdict = out_mem[out_rptr_reg];

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (out_wr && !out_rd)
        begin
            out_cnt_next = out_cnt_reg + 2'd1;
        end
        else if (out_rd && !out_wr)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= hslp_pkg::PH_START;
            major_reg    <= '0;
            minor_reg    <= '0;
            code_reg     <= '0;
            digits_reg   <= '0;
            pos_reg      <= '0;
            dstart_reg   <= '0;
            verdict_reg  <= 1'b0;
            out_wptr_reg <= 1'b0;
            out_rptr_reg <= 1'b0;
            out_cnt_reg  <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            major_reg    <= major_next;
            minor_reg    <= minor_next;
            code_reg     <= code_next;
            digits_reg   <= digits_next;
            pos_reg      <= pos_next;
            dstart_reg   <= dstart_next;
            verdict_reg  <= verdict_next;
            out_wptr_reg <= out_wr ? ~out_wptr_reg : out_wptr_reg;
            out_rptr_reg <= out_rd ? ~out_rptr_reg : out_rptr_reg;
            out_cnt_reg  <= out_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_wr)
        begin
            out_mem[out_wptr_reg] <= res_item;
        end
    end

endmodule

/* src/http_status_line_parser_core.sv */
// Path: a byte beat accepted into the front-end register goes through the
// command queue write, then the result queue write, to the result ports.
// Throughput: one byte beat per cycle, set by the one-state-step parser;
// a verdict beat left waiting stalls the parser only once two are queued.
// Reset: rst_n is asynchronous and active low; it empties all queues and
// returns the parser to the start of a buffer, expecting the letter H.
`timescale 1ns / 1ps

// Top level of the HTTP response status line parser. It instantiates the
// front end, the command queue and the parser back end from hslp_pkg types.
//
// Each input beat carries one byte of a response header buffer plus a flag
// on the buffer's last byte. The front end classifies the byte (digit,
// space, dot, CR, LF, the letters of the protocol name, slash or other)
// and places it in a four-entry queue. The back end walks the status line
// one byte per cycle while its result queue has room: the literal HTTP/, a
// major and a minor version that saturate at 999, a three-digit status code
// with spaces skipped, then any text up to CR LF or a bare LF. Exactly one
// verdict beat is produced per buffer; bytes after the verdict are dropped
// until the last byte, which always resets the parser for the next buffer.

module http_status_line_parser_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  hslp_pkg::in_item_t  byte_beat,
    output logic                empty,
    input  logic                pop,
    output hslp_pkg::out_item_t verdict
);

    hslp_pkg::q_stat_t   q_stat;
    hslp_pkg::cls_item_t front_item;
    hslp_pkg::cls_item_t head_item;
    logic                q_push;
    logic                q_pop;

    // Classification stage; it holds one byte while the queue is full.
    hslp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_beat (byte_beat),
        .q_stat    (q_stat),
        .q_push    (q_push),
        .q_item    (front_item)
    );

    // Decouples the front end from parser stalls on the result side.
    hslp_cmd_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_item (front_item),
        .rd_en   (q_pop),
        .rd_item (head_item),
        .stat    (q_stat)
    );

    // Parse state machine and result queue.
    hslp_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_stat  (q_stat),
        .q_item  (head_item),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .verdict (verdict)
    );

endmodule
